/* hdl/hbd_mbc1_pkg.sv */
// Shared types and constants for the handheld bus decoder with MBC1 banking.
package hbd_mbc1_pkg;

    localparam int STORE_DEPTH   = 32768;
    localparam int STORE_AW      = $clog2(STORE_DEPTH);
    localparam int ROM_ADDR_BITS = 21;
    localparam int ROM_BASE_BITS = 15;
    localparam int EXT_W         = 21;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAPPER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT   = 2'd2;

    localparam logic [1:0] SRC_DATA = 2'd0;
    localparam logic [1:0] SRC_CART = 2'd1;
    localparam logic [1:0] SRC_BOOT = 2'd2;

    localparam logic [15:0] ADDR_JOYP = 16'hFF00;
    localparam logic [15:0] ADDR_SC   = 16'hFF02;
    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;
    localparam logic [15:0] ADDR_IF   = 16'hFF0F;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_LY   = 16'hFF44;
    localparam logic [15:0] ADDR_DMA  = 16'hFF46;
    localparam logic [15:0] ADDR_BOOT = 16'hFF50;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_status;

endpackage

/* hdl/hbd_mbc1_ctrl.sv */
// Sequencer: store clearing pass after reset, then accept and execute.
module hbd_mbc1_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  hbd_mbc1_pkg::t_status i_status,
    output hbd_mbc1_pkg::t_cmd    o_cmd
);

    hbd_mbc1_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hbd_mbc1_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != hbd_mbc1_pkg::S_IDLE);

    always_comb begin
        n_state      = r_state;
        o_cmd.clear  = 1'b0;
        o_cmd.accept = 1'b0;
        o_cmd.exec   = 1'b0;
        case (r_state)
            hbd_mbc1_pkg::S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = hbd_mbc1_pkg::S_IDLE;
                end
            end
            hbd_mbc1_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = hbd_mbc1_pkg::S_EXEC;
                end
            end
            hbd_mbc1_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = hbd_mbc1_pkg::S_IDLE;
            end
            default: begin
                n_state = hbd_mbc1_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/hbd_mbc1_dp.sv */
// Datapath: work store, bank and config registers, map decode, result registers.
module hbd_mbc1_dp #(
    parameter int ROM_ADDR_BITS = hbd_mbc1_pkg::ROM_ADDR_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  hbd_mbc1_pkg::t_cmd                    i_cmd_ctl,
    output hbd_mbc1_pkg::t_status                 o_status,
    input  logic                                  i_cfg_we,
    input  logic [hbd_mbc1_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hbd_mbc1_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                                  i_cmd,
    input  logic [15:0]                           i_bus_address,
    input  logic [7:0]                            i_write_data,
    input  logic [7:0]                            i_joypad_lines,
    output logic                                  o_valid,
    output logic [7:0]                            o_read_data,
    output logic [1:0]                            o_data_source,
    output logic [hbd_mbc1_pkg::EXT_W-1:0]        o_external_address,
    output logic                                  o_timer_reset,
    output logic                                  o_dma_request,
    output logic [7:0]                            o_dma_page
);

    localparam int AW = hbd_mbc1_pkg::STORE_AW;
    localparam int EW = hbd_mbc1_pkg::EXT_W;

    logic [7:0] mem [hbd_mbc1_pkg::STORE_DEPTH];

    logic          r_mapper;
    logic [2:0]    r_size_code;
    logic          r_boot_on;
    logic [4:0]    r_lo_bank;
    logic [1:0]    r_hi_bank;
    logic          r_bank_mode;
    logic [AW-1:0] r_clr_addr;

    logic          r_cmd;
    logic [15:0]   r_addr;
    logic [7:0]    r_wdata;
    logic [7:0]    r_joy;
    logic [AW-1:0] r_idx;
    logic [7:0]    r_mem_q;

    logic [AW-1:0] in_idx;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;

    logic          st_we;
    logic [7:0]    st_wdata;
    logic          n_boot_off;
    logic          n_lo_we, n_hi_we, n_mode_we;
    logic [4:0]    lo_val;
    logic [7:0]    n_rd;
    logic [1:0]    n_src;
    logic [EW-1:0] n_ext;
    logic          n_tmr, n_dma;
    logic [7:0]    n_page;

    logic          boot_hit, io_unused, oam_unused, cram, is_echo;
    logic [15:0]   folded;
    logic [6:0]    bank;
    logic [EW-1:0] bank_adr;
    logic [4:0]    exp_sz, rom_bits;
    logic          over;
    logic [7:0]    joy_new;

    // echo 0xE000-0xFDFF folds down by 0x2000
    always_comb begin
        is_echo = (i_bus_address >= 16'hE000) && (i_bus_address <= 16'hFDFF);
        folded  = is_echo ? (i_bus_address - 16'h2000) : i_bus_address;
        in_idx  = folded[AW-1:0];
    end

    assign o_status.clear_last = &r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd_ctl.clear) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.accept) begin
            r_cmd   <= i_cmd;
            r_addr  <= i_bus_address;
            r_wdata <= i_write_data;
            r_joy   <= i_joypad_lines;
            r_idx   <= in_idx;
            r_mem_q <= mem[in_idx];
        end
    end

    always_comb begin
        mem_we    = i_cmd_ctl.clear || (i_cmd_ctl.exec && st_we);
        mem_waddr = i_cmd_ctl.clear ? r_clr_addr : r_idx;
        mem_wdata = i_cmd_ctl.clear ? 8'h00 : st_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mapper    <= 1'b0;
            r_size_code <= 3'd0;
            r_boot_on   <= 1'b0;
            r_lo_bank   <= 5'd1;
            r_hi_bank   <= 2'd0;
            r_bank_mode <= 1'b0;
        end else begin
            if (i_cmd_ctl.exec) begin
                if (n_boot_off) begin
                    r_boot_on <= 1'b0;
                end
                if (n_lo_we) begin
                    r_lo_bank <= lo_val;
                end
                if (n_hi_we) begin
                    r_hi_bank <= r_wdata[1:0];
                end
                if (n_mode_we) begin
                    r_bank_mode <= r_wdata[0];
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hbd_mbc1_pkg::CFG_MAPPER: r_mapper <= i_cfg_data[0];
                    hbd_mbc1_pkg::CFG_SIZE:   r_size_code <= i_cfg_data;
                    hbd_mbc1_pkg::CFG_BOOT:   r_boot_on <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // MBC1 bank address and ROM size limit
    always_comb begin
        bank     = {(r_bank_mode ? 2'b00 : r_hi_bank), r_lo_bank};
        bank_adr = {bank, r_addr[13:0]};
        exp_sz   = 5'(hbd_mbc1_pkg::ROM_BASE_BITS) + 5'(r_size_code);
        rom_bits = (exp_sz < 5'(ROM_ADDR_BITS)) ? exp_sz : 5'(ROM_ADDR_BITS);
        over     = (bank_adr >> rom_bits) != '0;
        lo_val   = (r_wdata[4:0] == 5'd0) ? 5'd1 : r_wdata[4:0];
    end

    // joypad refresh of the low nibble
    always_comb begin
        if (!r_mem_q[4]) begin
            joy_new = {r_mem_q[7:4], r_joy[7:4]};
        end else if (!r_mem_q[5]) begin
            joy_new = {r_mem_q[7:4], r_joy[3:0]};
        end else begin
            joy_new = r_mem_q;
        end
    end

    always_comb begin
        boot_hit   = (r_addr[15:8] == 8'h00) && r_boot_on;
        io_unused  = (r_addr >= 16'hFF4C) && (r_addr < 16'hFF80);
        oam_unused = (r_addr >= 16'hFEA0) && (r_addr < 16'hFF00);
        cram       = (r_addr[15:13] == 3'b101);

        st_we      = 1'b0;
        st_wdata   = r_wdata;
        n_boot_off = 1'b0;
        n_lo_we    = 1'b0;
        n_hi_we    = 1'b0;
        n_mode_we  = 1'b0;
        n_rd       = 8'h00;
        n_src      = hbd_mbc1_pkg::SRC_DATA;
        n_ext      = '0;
        n_tmr      = 1'b0;
        n_dma      = 1'b0;
        n_page     = 8'h00;

        if (!r_cmd) begin
            if (boot_hit) begin
                n_src = hbd_mbc1_pkg::SRC_BOOT;
                n_ext = EW'(r_addr);
            end else if (io_unused) begin
                n_rd = 8'hFF;
            end else if (oam_unused) begin
                n_rd = 8'h00;
            end else if (cram) begin
                n_rd = 8'hFF;
            end else if (r_addr[15:14] == 2'b00) begin
                n_src = hbd_mbc1_pkg::SRC_CART;
                n_ext = EW'(r_addr);
            end else if (r_addr[15:14] == 2'b01) begin
                if (!r_mapper) begin
                    n_src = hbd_mbc1_pkg::SRC_CART;
                    n_ext = EW'(r_addr);
                end else if (over) begin
                    n_rd = 8'hFF;
                end else begin
                    n_src = hbd_mbc1_pkg::SRC_CART;
                    n_ext = bank_adr;
                end
            end else if (r_addr == hbd_mbc1_pkg::ADDR_JOYP) begin
                st_we    = 1'b1;
                st_wdata = joy_new;
                n_rd     = joy_new;
            end else begin
                n_rd = r_mem_q;
            end
        end else begin
            if (boot_hit) begin
                st_we = 1'b0;
            end else if (io_unused) begin
                n_boot_off = (r_addr == hbd_mbc1_pkg::ADDR_BOOT) && (r_wdata == 8'h01);
            end else if (oam_unused || cram) begin
                st_we = 1'b0;
            end else if (r_addr == hbd_mbc1_pkg::ADDR_DIV) begin
                st_we    = 1'b1;
                st_wdata = 8'h00;
                n_tmr    = 1'b1;
            end else if (r_addr == hbd_mbc1_pkg::ADDR_LY) begin
                st_we    = 1'b1;
                st_wdata = 8'h00;
            end else if (r_addr == hbd_mbc1_pkg::ADDR_DMA) begin
                n_dma  = 1'b1;
                n_page = r_wdata;
            end else if (r_addr == hbd_mbc1_pkg::ADDR_JOYP) begin
                st_we    = 1'b1;
                st_wdata = (r_mem_q & 8'hCF) | (r_wdata & 8'h30);
            end else if (r_addr == hbd_mbc1_pkg::ADDR_SC) begin
                st_we    = 1'b1;
                st_wdata = r_wdata | 8'h7E;
            end else if (r_addr == hbd_mbc1_pkg::ADDR_TAC) begin
                st_we    = 1'b1;
                st_wdata = r_wdata | 8'hF8;
            end else if (r_addr == hbd_mbc1_pkg::ADDR_IF) begin
                st_we    = 1'b1;
                st_wdata = r_wdata | 8'hE0;
            end else if (r_addr == hbd_mbc1_pkg::ADDR_STAT) begin
                st_we    = 1'b1;
                st_wdata = r_wdata | 8'h80;
            end else if (!r_addr[15]) begin
                if (r_mapper) begin
                    case (r_addr[14:13])
                        2'b01:   n_lo_we   = 1'b1;
                        2'b10:   n_hi_we   = 1'b1;
                        2'b11:   n_mode_we = 1'b1;
                        default: ;
                    endcase
                end
            end else begin
                st_we = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd_ctl.exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_ctl.exec) begin
            o_read_data        <= n_rd;
            o_data_source      <= n_src;
            o_external_address <= n_ext;
            o_timer_reset      <= n_tmr;
            o_dma_request      <= n_dma;
            o_dma_page         <= n_page;
        end
    end

endmodule

/* hdl/handheld_bus_decoder_mbc1_core.sv */
// Top level of the handheld bus decoder with MBC1 banking.
// After reset, busy stays high while the work store is
// cleared one byte a cycle; configuration writes are taken during that time.
// An access is taken on a clock edge with start high and busy low. For
// each access the store is read on the accepting edge, and the store
// write-back and result registers load on the next edge. The result word is
// on the o_ ports for one cycle marked by o_valid, and there is no stall on
// that side; a new start may be given in that same cycle.
module handheld_bus_decoder_mbc1_core #(
    parameter int ROM_ADDR_BITS = hbd_mbc1_pkg::ROM_ADDR_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hbd_mbc1_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hbd_mbc1_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_cmd,
    input  logic [15:0]                         i_bus_address,
    input  logic [7:0]                          i_write_data,
    input  logic [7:0]                          i_joypad_lines,
    output logic                                o_valid,
    output logic [7:0]                          o_read_data,
    output logic [1:0]                          o_data_source,
    output logic [hbd_mbc1_pkg::EXT_W-1:0]      o_external_address,
    output logic                                o_timer_reset,
    output logic                                o_dma_request,
    output logic [7:0]                          o_dma_page
);

    hbd_mbc1_pkg::t_cmd    cmd_ctl;
    hbd_mbc1_pkg::t_status status;

    hbd_mbc1_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd_ctl)
    );

    hbd_mbc1_dp #(
        .ROM_ADDR_BITS (ROM_ADDR_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd_ctl          (cmd_ctl),
        .o_status           (status),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (i_cmd),
        .i_bus_address      (i_bus_address),
        .i_write_data       (i_write_data),
        .i_joypad_lines     (i_joypad_lines),
        .o_valid            (o_valid),
        .o_read_data        (o_read_data),
        .o_data_source      (o_data_source),
        .o_external_address (o_external_address),
        .o_timer_reset      (o_timer_reset),
        .o_dma_request      (o_dma_request),
        .o_dma_page         (o_dma_page)
    );

endmodule
